// ----- src/nca_pkg.sv -----
`default_nettype none

package nca_pkg;

  localparam int CoordBits           = 16;
  localparam int CountBits           = 5;
  localparam int IndexBits           = 4;
  localparam int SqBits              = 2 * CoordBits;
  localparam int DistBits            = SqBits + 2;
  localparam int MaxCentroidsDefault = 16;
  localparam int QueueDepth          = 2;

  localparam logic CmdLoad  = 1'b0;
  localparam logic CmdQuery = 1'b1;

  typedef struct packed {
    logic                        command;
    logic [IndexBits-1:0]        entry_index;
    logic signed [CoordBits-1:0] coord_x;
    logic signed [CoordBits-1:0] coord_y;
    logic signed [CoordBits-1:0] coord_z;
  } in_word_t;

  typedef struct packed {
    logic [IndexBits-1:0] nearest_index;
    logic                 found;
    logic [DistBits-1:0]  min_distance_sq;
  } out_word_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] coord_x;
    logic signed [CoordBits-1:0] coord_y;
    logic signed [CoordBits-1:0] coord_z;
  } point_t;

  typedef struct packed {
    logic                 is_query;
    logic                 load_ok;
    logic [IndexBits-1:0] entry_index;
    point_t               point;
  } op_t;

endpackage

`default_nettype wire

// ----- src/nearest_centroid_assign.sv -----
// Channel  Dir  Handshake                  Word
// in       in   in_valid_i / in_stall_o    nca_pkg::in_word_t
// out      out  out_valid_o / out_stall_i  nca_pkg::out_word_t
// cfg      in   cfg_we_i                   cfg_wdata_i (centroid_count)
//
// A query in the back end scans n = min(centroid_count, MAX_CENTROIDS) centroids, one table
// read each through the single read port, in four pipe stages: read, abs, square, sum.
// A load passes the front register and the queue to the table; n = 0 queries skip the search.
// Reset clears centroid_count, the queue and all valid flags; table contents stay undefined.
// A two-word queue lets the input side keep accepting while a query runs, and a finished
// result waits in the output register while the back end takes further loads.
`default_nettype none

module nearest_centroid_assign #(
  parameter int MAX_CENTROIDS = nca_pkg::MaxCentroidsDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire nca_pkg::in_word_t             in_word_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output nca_pkg::out_word_t                 out_word_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [nca_pkg::CountBits-1:0] cfg_wdata_i
);
  import nca_pkg::*;

  op_t  front_op, queue_op;
  logic push, full, pop, empty;

  nca_front #(
    .MAX_CENTROIDS(MAX_CENTROIDS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_word_i (in_word_i),
    .push_o    (push),
    .op_o      (front_op),
    .full_i    (full)
  );

  nca_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .op_i   (front_op),
    .full_o (full),
    .pop_i  (pop),
    .op_o   (queue_op),
    .empty_o(empty)
  );

  nca_back #(
    .MAX_CENTROIDS(MAX_CENTROIDS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .op_i       (queue_op),
    .empty_i    (empty),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

endmodule

`default_nettype wire

// ----- src/nca_front.sv -----
`default_nettype none

module nca_front #(
  parameter int MAX_CENTROIDS = nca_pkg::MaxCentroidsDefault
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire nca_pkg::in_word_t in_word_i,
  output logic                  push_o,
  output nca_pkg::op_t          op_o,
  input  wire logic             full_i
);
  import nca_pkg::*;

  logic valid_q, valid_d;
  logic accept;
  op_t  op_q, op_dec;

  always_comb begin
    op_dec.is_query    = 1'b0;
    unique case (in_word_i.command)
      CmdLoad:  op_dec.is_query = 1'b0;
      CmdQuery: op_dec.is_query = 1'b1;
      default:  op_dec.is_query = 1'b0;
    endcase
    op_dec.load_ok     = (int'(in_word_i.entry_index) < MAX_CENTROIDS);
    op_dec.entry_index = in_word_i.entry_index;
    op_dec.point       = '{coord_x: in_word_i.coord_x,
                           coord_y: in_word_i.coord_y,
                           coord_z: in_word_i.coord_z};
  end

  assign in_stall_o = valid_q && full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = valid_q;
  assign op_o       = op_q;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (valid_q && !full_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= op_dec;
    end
  end

endmodule

`default_nettype wire

// ----- src/nca_queue.sv -----
`default_nettype none

module nca_queue (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire nca_pkg::op_t op_i,
  output logic              full_o,
  input  wire logic         pop_i,
  output nca_pkg::op_t      op_o,
  output logic              empty_o
);
  import nca_pkg::*;

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  op_t             entries_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            push_en, pop_en;

  assign full_o  = (count_q == CntW'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign push_en = push_i && !full_o;
  assign pop_en  = pop_i && !empty_o;
  assign op_o    = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_en) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_en) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_en && !pop_en) begin
        count_q <= count_q + 1'b1;
      end else if (pop_en && !push_en) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_en) begin
      entries_q[wr_ptr_q] <= op_i;
    end
  end

endmodule

`default_nettype wire

// ----- src/nca_back.sv -----
`default_nettype none

module nca_back #(
  parameter int MAX_CENTROIDS = nca_pkg::MaxCentroidsDefault
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [nca_pkg::CountBits-1:0]  cfg_wdata_i,
  input  wire nca_pkg::op_t                   op_i,
  input  wire logic                           empty_i,
  output logic                                pop_o,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output nca_pkg::out_word_t                  out_word_o
);
  import nca_pkg::*;

  localparam int IdxW = (MAX_CENTROIDS > 1) ? $clog2(MAX_CENTROIDS) : 1;
  localparam int NW   = (IdxW + 1 > CountBits) ? IdxW + 1 : CountBits;

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StSearch = 2'd1;
  localparam logic [1:0] StDrain  = 2'd2;
  localparam logic [1:0] StFinish = 2'd3;

  logic [1:0]           state_q, state_d;
  logic [CountBits-1:0] count_q;
  logic [NW-1:0]        count_ext, n_eff;
  logic [IdxW-1:0]      rd_addr_q, rd_addr_d, last_addr_q, last_addr_d;
  logic                 start, finish_ld, issue, wr_en, upd;

  point_t               table_q [MAX_CENTROIDS];
  point_t               pt_q, rd_pt_q;

  logic                 s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q;
  logic                 s1_last_q, s2_last_q, s3_last_q, s4_last_q;
  logic [IdxW-1:0]      s1_idx_q, s2_idx_q, s3_idx_q, s4_idx_q;

  logic signed [CoordBits:0] dx, dy, dz;
  logic [CoordBits-1:0] ax_q, ay_q, az_q;
  logic [SqBits-1:0]    sx_q, sy_q, sz_q;
  logic [DistBits-1:0]  dist_q, best_dist_q;
  logic [IdxW-1:0]      best_idx_q;
  logic                 found_q;
  logic                 out_valid_q;
  out_word_t            out_word_q;

  assign count_ext = NW'(count_q);
  assign n_eff     = (count_ext > NW'(MAX_CENTROIDS)) ? NW'(MAX_CENTROIDS) : count_ext;
  assign pop_o     = (state_q == StIdle) && !empty_i;
  assign issue     = (state_q == StSearch);
  assign wr_en     = pop_o && !op_i.is_query && op_i.load_ok;
  assign upd       = s4_vld_q && (!found_q || (dist_q < best_dist_q));

  always_comb begin
    state_d     = state_q;
    rd_addr_d   = rd_addr_q;
    last_addr_d = last_addr_q;
    start       = 1'b0;
    finish_ld   = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (!empty_i && op_i.is_query) begin
          start       = 1'b1;
          rd_addr_d   = '0;
          last_addr_d = IdxW'(n_eff - 1'b1);
          state_d     = (n_eff == '0) ? StFinish : StSearch;
        end
      end
      StSearch: begin
        if (rd_addr_q == last_addr_q) begin
          state_d = StDrain;
        end else begin
          rd_addr_d = rd_addr_q + 1'b1;
        end
      end
      StDrain: begin
        if (s4_vld_q && s4_last_q) begin
          state_d = StFinish;
        end
      end
      StFinish: begin
        if (!out_valid_q || !out_stall_i) begin
          finish_ld = 1'b1;
          state_d   = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      rd_addr_q   <= '0;
      last_addr_q <= '0;
      s1_vld_q    <= 1'b0;
      s2_vld_q    <= 1'b0;
      s3_vld_q    <= 1'b0;
      s4_vld_q    <= 1'b0;
      s1_last_q   <= 1'b0;
      s2_last_q   <= 1'b0;
      s3_last_q   <= 1'b0;
      s4_last_q   <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_addr_q   <= rd_addr_d;
      last_addr_q <= last_addr_d;
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
      s1_vld_q  <= issue;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q;
      s4_vld_q  <= s3_vld_q;
      s1_last_q <= issue && (rd_addr_q == last_addr_q);
      s2_last_q <= s1_last_q;
      s3_last_q <= s2_last_q;
      s4_last_q <= s3_last_q;
      if (start) begin
        found_q <= 1'b0;
      end else if (upd) begin
        found_q <= 1'b1;
      end
      if (finish_ld) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      table_q[IdxW'(op_i.entry_index)] <= op_i.point;
    end
    if (issue) begin
      rd_pt_q <= table_q[rd_addr_q];
    end
  end

  assign dx = {pt_q.coord_x[CoordBits-1], pt_q.coord_x}
            - {rd_pt_q.coord_x[CoordBits-1], rd_pt_q.coord_x};
  assign dy = {pt_q.coord_y[CoordBits-1], pt_q.coord_y}
            - {rd_pt_q.coord_y[CoordBits-1], rd_pt_q.coord_y};
  assign dz = {pt_q.coord_z[CoordBits-1], pt_q.coord_z}
            - {rd_pt_q.coord_z[CoordBits-1], rd_pt_q.coord_z};

  always_ff @(posedge clk_i) begin
    if (start) begin
      pt_q        <= op_i.point;
      best_dist_q <= '0;
      best_idx_q  <= '0;
    end else if (upd) begin
      best_dist_q <= dist_q;
      best_idx_q  <= s4_idx_q;
    end
    s1_idx_q <= rd_addr_q;
    s2_idx_q <= s1_idx_q;
    s3_idx_q <= s2_idx_q;
    s4_idx_q <= s3_idx_q;
    // The magnitude of a difference of two coordinates always fits CoordBits bits.
    ax_q   <= dx[CoordBits] ? CoordBits'(-dx) : CoordBits'(dx);
    ay_q   <= dy[CoordBits] ? CoordBits'(-dy) : CoordBits'(dy);
    az_q   <= dz[CoordBits] ? CoordBits'(-dz) : CoordBits'(dz);
    sx_q   <= SqBits'(ax_q) * SqBits'(ax_q);
    sy_q   <= SqBits'(ay_q) * SqBits'(ay_q);
    sz_q   <= SqBits'(az_q) * SqBits'(az_q);
    dist_q <= DistBits'(sx_q) + DistBits'(sy_q) + DistBits'(sz_q);
    if (finish_ld) begin
      out_word_q <= '{nearest_index:   IndexBits'(best_idx_q),
                      found:           found_q,
                      min_distance_sq: best_dist_q};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

`ifndef SYNTHESIS
  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == StFinish))
    else $error("result appeared without a finished query");

  a_pipe_empty_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> !(s1_vld_q || s2_vld_q || s3_vld_q || s4_vld_q))
    else $error("distance pipeline busy while idle");

  a_last_ends_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s4_vld_q && s4_last_q) |=> (state_q == StFinish))
    else $error("last distance did not close the query");

  a_not_found_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_word_q.found) |->
      (out_word_q.min_distance_sq == '0 && out_word_q.nearest_index == '0))
    else $error("empty search returned a nonzero result");
`endif

endmodule

`default_nettype wire

// ----- sim/tb_nearest_centroid_assign.sv -----
`timescale 1ns / 1ps

module tb_nearest_centroid_assign;
  import nca_pkg::*;

  localparam int SettleCycles = 32;
  localparam int QuietLimit   = 5000;
  localparam int HoldCycles   = 400;
  localparam int SegmentWords = 160;

  typedef enum logic {RowCfg, RowWord} row_kind_e;

  typedef struct {
    row_kind_e            kind;
    logic [CountBits-1:0] count;
    in_word_t             word;
    bit                   typed;
    out_word_t            want;
  } dir_row_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  in_word_t             in_word_i   = '0;
  logic                 out_stall_i = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CountBits-1:0] cfg_wdata_i = '0;
  logic                 in_stall_o;
  logic                 out_valid_o;
  out_word_t            out_word_o;

  point_t               centroid_tab [MaxCentroidsDefault];
  logic [CountBits-1:0] centroid_limit = '0;
  out_word_t            awaited_assignments [$];
  out_word_t            oldest;
  dir_row_t             directed_rows [$];

  int send_idle_pct = 33;
  int recv_idle_pct = 47;
  bit hold_req      = 1'b0;
  bit hold_used     = 1'b0;
  int hold_left     = 0;
  int quiet_cycles  = 0;

  int loads_sent          = 0;
  int queries_sent        = 0;
  int assignments_checked = 0;
  int mismatches          = 0;

  int count_plan [12] = '{16, 0, 31, 1, 9, 17, 15, 2, 16, 30, 4, 12};

  nearest_centroid_assign uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic out_word_t nearest_centroid(point_t q);
    out_word_t r;
    int        n;
    longint    dx, dy, dz, d, best;
    r    = '0;
    best = 0;
    n    = (centroid_limit > MaxCentroidsDefault) ? MaxCentroidsDefault
                                                  : int'(centroid_limit);
    for (int i = 0; i < n; i++) begin
      dx = longint'(q.coord_x) - longint'(centroid_tab[i].coord_x);
      dy = longint'(q.coord_y) - longint'(centroid_tab[i].coord_y);
      dz = longint'(q.coord_z) - longint'(centroid_tab[i].coord_z);
      d  = dx * dx + dy * dy + dz * dz;
      if (!r.found || d < best) begin
        best            = d;
        r.nearest_index = IndexBits'(i);
        r.found         = 1'b1;
      end
    end
    r.min_distance_sq = best[DistBits-1:0];
    return r;
  endfunction

  function automatic in_word_t make_word(logic cmd, int idx, int x, int y, int z);
    in_word_t w;
    w.command     = cmd;
    w.entry_index = idx[IndexBits-1:0];
    w.coord_x     = x[CoordBits-1:0];
    w.coord_y     = y[CoordBits-1:0];
    w.coord_z     = z[CoordBits-1:0];
    return w;
  endfunction

  function automatic dir_row_t word_row(logic cmd, int idx, int x, int y, int z);
    dir_row_t row;
    row.kind  = RowWord;
    row.count = '0;
    row.word  = make_word(cmd, idx, x, y, z);
    row.typed = 1'b0;
    row.want  = '0;
    return row;
  endfunction

  function automatic dir_row_t checked_row(int x, int y, int z, int want_idx,
                                           logic want_found, longint want_dist);
    dir_row_t row;
    row                       = word_row(CmdQuery, 0, x, y, z);
    row.typed                 = 1'b1;
    row.want.nearest_index    = want_idx[IndexBits-1:0];
    row.want.found            = want_found;
    row.want.min_distance_sq  = want_dist[DistBits-1:0];
    return row;
  endfunction

  function automatic dir_row_t cfg_row(int v);
    dir_row_t row;
    row       = word_row(CmdLoad, 0, 0, 0, 0);
    row.kind  = RowCfg;
    row.count = v[CountBits-1:0];
    return row;
  endfunction

  function automatic void add_row(dir_row_t row);
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  function automatic int rand_coord(int base);
    logic [15:0] raw;
    raw = 16'($urandom);
    case ($urandom_range(0, 5))
      0:       return -32768;
      1:       return 32767;
      2:       return base;
      3:       return base + int'($urandom_range(0, 6)) - 3;
      4:       return int'($urandom_range(0, 16)) - 8;
      default: return int'($signed(raw));
    endcase
  endfunction

  function automatic in_word_t random_word();
    point_t c;
    logic   cmd;
    int     x, y, z;
    c   = centroid_tab[$urandom_range(0, MaxCentroidsDefault - 1)];
    cmd = ($urandom_range(0, 99) < 60) ? CmdQuery : CmdLoad;
    if ($urandom_range(0, 4) == 0) begin
      x = int'(c.coord_x) + int'($urandom_range(0, 1));
      y = int'(c.coord_y);
      z = int'(c.coord_z);
    end else begin
      x = rand_coord(int'(c.coord_x));
      y = rand_coord(int'(c.coord_y));
      z = rand_coord(int'(c.coord_z));
    end
    return make_word(cmd, $urandom_range(0, 15), x, y, z);
  endfunction

  task automatic send_word(input in_word_t w, input bit typed, input out_word_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (w.command == CmdLoad) begin
      centroid_tab[w.entry_index] = point_t'{w.coord_x, w.coord_y, w.coord_z};
      loads_sent++;
    end else begin
      awaited_assignments.insert(awaited_assignments.size(),
          typed ? want : nearest_centroid(point_t'{w.coord_x, w.coord_y, w.coord_z}));
      queries_sent++;
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (awaited_assignments.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_centroid_count(input logic [CountBits-1:0] v);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i       <= 1'b0;
    centroid_limit  = v;
  endtask

  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (hold_req && !hold_used) begin
      hold_used   <= 1'b1;
      hold_left   <= HoldCycles;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_assignments.size() == 0) begin
        $error("tb: unexpected result word, index %0d found %0d distance %0d",
               out_word_o.nearest_index, out_word_o.found, out_word_o.min_distance_sq);
        mismatches++;
      end else begin
        oldest = awaited_assignments.pop_front();
        assignments_checked++;
        if (out_word_o.nearest_index !== oldest.nearest_index) begin
          $error("tb: nearest_index expected %0d actual %0d",
                 oldest.nearest_index, out_word_o.nearest_index);
          mismatches++;
        end
        if (out_word_o.found !== oldest.found) begin
          $error("tb: found expected %0d actual %0d", oldest.found, out_word_o.found);
          mismatches++;
        end
        if (out_word_o.min_distance_sq !== oldest.min_distance_sq) begin
          $error("tb: min_distance_sq expected %0d actual %0d",
                 oldest.min_distance_sq, out_word_o.min_distance_sq);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QuietLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    add_row(checked_row(0, 0, 0, 0, 1'b0, 0));
    add_row(checked_row(-32768, 32767, -32768, 0, 1'b0, 0));
    add_row(word_row(CmdLoad, 0, 32767, 32767, 32767));
    add_row(cfg_row(1));
    add_row(checked_row(-32768, -32768, -32768, 0, 1'b1, 64'd12884508675));
    add_row(checked_row(32767, 32767, 32767, 0, 1'b1, 0));
    add_row(word_row(CmdLoad, 1, -32768, -32768, -32768));
    add_row(word_row(CmdLoad, 2, 32767, 32767, 32767));
    add_row(cfg_row(3));
    add_row(checked_row(32767, 32767, 32767, 0, 1'b1, 0));
    add_row(checked_row(-32768, -32768, -32768, 1, 1'b1, 0));
    add_row(word_row(CmdQuery, 0, 0, 0, 0));
    add_row(word_row(CmdQuery, 0, -1, -1, -1));
    for (int i = 3; i < MaxCentroidsDefault; i++) begin
      add_row(word_row(CmdLoad, i, i * 3000 - 24000, 20000 - i * 2500,
                       (i % 2) ? 12345 - i : -77 * i));
    end
    add_row(cfg_row(31));
    add_row(checked_row(-32768, -32768, -32768, 1, 1'b1, 0));
    add_row(word_row(CmdQuery, 0, 100, -200, 300));
    add_row(cfg_row(16));
    add_row(word_row(CmdQuery, 0, 1, 1, 1));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == RowCfg) begin
        set_centroid_count(directed_rows[r].count);
      end else begin
        send_word(directed_rows[r].word, directed_rows[r].typed, directed_rows[r].want);
      end
    end

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct <= 33;
          recv_idle_pct <= 47;
        end
        1: begin
          send_idle_pct <= 47;
          recv_idle_pct <= 33;
        end
        default: begin
          send_idle_pct <= 0;
          recv_idle_pct <= 0;
        end
      endcase
      for (int seg = 0; seg < 4; seg++) begin
        set_centroid_count(CountBits'(count_plan[phase * 4 + seg]));
        if (phase == 2 && seg == 1) hold_req <= 1'b1;
        for (int k = 0; k < SegmentWords; k++) begin
          if (phase == 0 && seg == 1 && k == SegmentWords / 2) wait_drained();
          send_word(random_word(), 1'b0, '0);
        end
      end
    end

    wait_drained();
    $display("tb: %0d loads and %0d queries sent, %0d result words checked",
             loads_sent, queries_sent, assignments_checked);
    $display("tb: centroid counts from 0 to 31 under three idling mixes and one long hold");
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/nca_pkg.sv
src/nca_front.sv
src/nca_queue.sv
src/nca_back.sv
src/nearest_centroid_assign.sv
sim/tb_nearest_centroid_assign.sv
